// ----- hdl/rpnm_pkg.sv -----
package rpnm_pkg;

  // Default number of tracking cells
  localparam int DEF_CHANNELS = 10;

  // Fixed field widths
  localparam int MZ_W    = 32;
  localparam int LEVEL_W = 32;
  localparam int TOL_W   = 16;
  localparam int CHAN_W  = 4;
  localparam int CFG_W   = 2;

  // Configuration register indexes
  localparam logic [CFG_W-1:0] REG_LABEL_SET = 2'd0;
  localparam logic [CFG_W-1:0] REG_TOLERANCE = 2'd1;

  // Reset values of the configuration registers
  localparam logic             LABEL_SET_RST = 1'b0;
  localparam logic [TOL_W-1:0] TOLERANCE_RST = 16'd4000;

  // Table sizes of the two label sets
  localparam int SIZE_TEN   = 10;
  localparam int SIZE_EIGHT = 8;

  // Reference masses in 0.0001 Da units
  localparam logic [MZ_W-1:0] MASS_TEN [SIZE_TEN] = '{
    32'd1240000, 32'd1250000, 32'd1260000, 32'd1270000, 32'd1280000,
    32'd1290000, 32'd1300000, 32'd1310000, 32'd1320000, 32'd1330000
  };
  localparam logic [MZ_W-1:0] MASS_EIGHT [SIZE_EIGHT] = '{
    32'd1121000, 32'd1131000, 32'd1141112, 32'd1151083,
    32'd1161116, 32'd1171150, 32'd1181000, 32'd1191000
  };

  // Control fan-out from the sequencer to every cell
  typedef struct packed {
    logic update;     // request accepted, fold the peak in
    logic first;      // first peak of the spectrum
    logic capture;    // last peak, copy the result into the drain stage
    logic check;      // apply the tolerance to the drain stage
    logic shift;      // move the drain stage one cell toward the head
    logic live_set;   // label set for tracking
    logic drain_set;  // label set of the spectrum being drained
  } cell_ctrl_t;

  // Reference mass of one channel for a label set
  function automatic logic [MZ_W-1:0] ref_mass(input logic set, input int idx);
    logic [MZ_W-1:0] m;
    m = '0;
    if (set) begin
      if (idx < SIZE_EIGHT) m = MASS_EIGHT[idx];
    end else begin
      if (idx < SIZE_TEN) m = MASS_TEN[idx];
    end
    return m;
  endfunction

  // Absolute difference of two masses
  function automatic logic [MZ_W-1:0] abs_diff(input logic [MZ_W-1:0] a,
                                               input logic [MZ_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Channels in use for a label set, capped at the cell count
  function automatic logic [CHAN_W-1:0] chan_count(input logic set,
                                                   input int channels);
    int size;
    size = set ? SIZE_EIGHT : SIZE_TEN;
    if (channels < size) size = channels;
    return CHAN_W'(size);
  endfunction

endpackage

// ----- hdl/rpnm_cell.sv -----
module rpnm_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  rpnm_pkg::cell_ctrl_t          ctrl,
  input  logic [rpnm_pkg::MZ_W-1:0]     peak_mz,
  input  logic [rpnm_pkg::LEVEL_W-1:0]  peak_intensity,
  input  logic [rpnm_pkg::TOL_W-1:0]    tolerance,
  input  logic [rpnm_pkg::LEVEL_W-1:0]  shift_in,
  output logic [rpnm_pkg::LEVEL_W-1:0]  level_out,
  output logic                          match
);
  import rpnm_pkg::*;

  logic [MZ_W-1:0]    best_mass;
  logic [LEVEL_W-1:0] best_level;
  logic [MZ_W-1:0]    best_mass_next;
  logic [LEVEL_W-1:0] best_level_next;
  logic [MZ_W-1:0]    drain_mass;
  logic [LEVEL_W-1:0] drain_level;
  logic [MZ_W-1:0]    live_ref;
  logic [MZ_W-1:0]    drain_ref;
  logic [MZ_W-1:0]    dist_new;
  logic [MZ_W-1:0]    dist_kept;
  logic [MZ_W-1:0]    dist_drain;
  logic               take;
  logic               in_use;

  // Pick the closer peak, larger mass on a tie, earlier peak on equal mass
  always_comb begin
    in_use    = (IDX < (ctrl.live_set ? SIZE_EIGHT : SIZE_TEN));
    live_ref  = ref_mass(ctrl.live_set, IDX);
    dist_new  = abs_diff(peak_mz, live_ref);
    dist_kept = abs_diff(best_mass, live_ref);
    take = ctrl.first || (dist_new < dist_kept) ||
           ((dist_new == dist_kept) && (peak_mz > best_mass));
    best_mass_next  = take ? peak_mz : best_mass;
    best_level_next = take ? peak_intensity : best_level;
  end

  // Tolerance check on the captured result
  always_comb begin
    drain_ref  = ref_mass(ctrl.drain_set, IDX);
    dist_drain = abs_diff(drain_mass, drain_ref);
    match      = dist_drain < {{(MZ_W-TOL_W){1'b0}}, tolerance};
  end

  // Hold the kept peak; a channel outside the current table keeps its value
  always_ff @(posedge clk) begin
    if (ctrl.update && in_use) begin
      best_mass  <= best_mass_next;
      best_level <= best_level_next;
    end
  end

  // Capture, zero on miss, then shift toward the head
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      drain_mass  <= best_mass_next;
      drain_level <= best_level_next;
    end else if (ctrl.check) begin
      if (!match) drain_level <= '0;
    end else if (ctrl.shift) begin
      drain_level <= shift_in;
    end
  end

  assign level_out = drain_level;

endmodule

// ----- hdl/reporter_peak_nearest_match.sv -----
// Throughput: one peak per cycle; a last peak waits while the previous
//   spectrum is still being checked or its results are still draining.
// After the edge that takes the last peak, the tolerance check runs in ST_CHECK;
//   with a match, results follow in ST_SHIFT, one per cycle while out_stall is low.
// Without a match the chain is busy only for the check and offers no result.
// Reset: configuration to defaults, drain idle, next peak starts a spectrum.
module reporter_peak_nearest_match #(
  parameter int CHANNELS = rpnm_pkg::DEF_CHANNELS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rpnm_pkg::CFG_W-1:0]    cfg_index,
  input  logic [rpnm_pkg::TOL_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [rpnm_pkg::MZ_W-1:0]     peak_mz,
  input  logic [rpnm_pkg::LEVEL_W-1:0]  peak_intensity,
  input  logic                          last_peak,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rpnm_pkg::CHAN_W-1:0]   channel,
  output logic [rpnm_pkg::LEVEL_W-1:0]  abundance,
  output logic                          last
);
  import rpnm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_SHIFT = 3'b100
  } drain_state_t;

  drain_state_t       state;
  drain_state_t       state_next;
  logic               label_set;
  logic [TOL_W-1:0]   match_tolerance;
  logic               awaiting_first;
  logic               drain_set;
  logic [CHAN_W-1:0]  count;
  logic [CHAN_W-1:0]  count_next;
  logic [CHAN_W-1:0]  drain_n;
  logic               accept;
  logic               any_match;
  logic               final_out;
  cell_ctrl_t         ctrl;
  logic [LEVEL_W-1:0] levels  [CHANNELS];
  logic [CHANNELS-1:0] hit_flags;

  assign cfg_ready = 1'b1;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      label_set       <= LABEL_SET_RST;
      match_tolerance <= TOLERANCE_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LABEL_SET) label_set <= cfg_data[0];
      if (cfg_index == REG_TOLERANCE) match_tolerance <= cfg_data;
    end
  end

  // Hold a last peak while the drain stage is busy
  assign in_stall = (state != ST_IDLE) && last_peak;
  assign accept   = in_valid && !in_stall;

  // Track the start of each spectrum
  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_first <= 1'b1;
    end else if (accept) begin
      awaiting_first <= last_peak;
    end
  end

  // Drive the cells
  always_comb begin
    ctrl.update    = accept;
    ctrl.first     = awaiting_first;
    ctrl.capture   = accept && last_peak;
    ctrl.check     = (state == ST_CHECK);
    ctrl.shift     = (state == ST_SHIFT) && !out_stall;
    ctrl.live_set  = label_set;
    ctrl.drain_set = drain_set;
  end

  // Row of tracking cells, drain data moves toward cell zero
  for (genvar k = 0; k < CHANNELS; k++) begin : g_cell
    logic [LEVEL_W-1:0] from_next;
    if (k == CHANNELS - 1) begin : g_tail
      assign from_next = '0;
    end else begin : g_link
      assign from_next = levels[k+1];
    end
    rpnm_cell #(
      .IDX(k)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .peak_mz       (peak_mz),
      .peak_intensity(peak_intensity),
      .tolerance     (match_tolerance),
      .shift_in      (from_next),
      .level_out     (levels[k]),
      .match         (hit_flags[k])
    );
  end

  // Any channel in use within tolerance
  always_comb begin
    drain_n   = chan_count(drain_set, CHANNELS);
    any_match = 1'b0;
    for (int k = 0; k < CHANNELS; k++) begin
      if ((CHAN_W'(k) < drain_n) && hit_flags[k]) any_match = 1'b1;
    end
  end

  assign final_out = (count == drain_n - CHAN_W'(1));

  // Sequence capture, check and drain
  always_comb begin
    state_next = state;
    count_next = count;
    unique case (state)
      ST_IDLE: begin
        if (ctrl.capture) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        count_next = '0;
        state_next = any_match ? ST_SHIFT : ST_IDLE;
      end
      ST_SHIFT: begin
        if (!out_stall) begin
          count_next = count + CHAN_W'(1);
          if (final_out) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Latch the label set of the spectrum being drained
  always_ff @(posedge clk) begin
    if (ctrl.capture) drain_set <= label_set;
  end

  assign out_valid = (state == ST_SHIFT);
  assign channel   = count;
  assign abundance = levels[0];
  assign last      = final_out;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rpnm_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PEAKS  = 320;
  localparam int CALM_TAIL     = 40;

  // Register indexes past the end of the map; writes to them must be dropped
  localparam logic [CFG_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_W-1:0] REG_SPARE_3 = 2'd3;

  // Reporter masses per label set, 0.0001 Da
  localparam logic [MZ_W-1:0] REPORTER_MZ [2][10] = '{
    '{32'd1240000, 32'd1250000, 32'd1260000, 32'd1270000, 32'd1280000,
      32'd1290000, 32'd1300000, 32'd1310000, 32'd1320000, 32'd1330000},
    '{32'd1121000, 32'd1131000, 32'd1141112, 32'd1151083, 32'd1161116,
      32'd1171150, 32'd1181000, 32'd1191000, 32'd0, 32'd0}
  };

  typedef enum logic {ROW_PEAK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [MZ_W-1:0]    mz;
    logic [LEVEL_W-1:0] level;
    logic               fin;
    logic [CFG_W-1:0]   idx;
    logic [TOL_W-1:0]   data;
    logic               typed;
    logic [CHAN_W:0]    n_res;
    logic [CHAN_W-1:0]  hit_chan;
    logic [LEVEL_W-1:0] hit_level;
  } plan_row_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan;
    logic [LEVEL_W-1:0] level;
    logic               fin;
  } abundance_t;

  logic                clk;
  logic                rst            = 1'b1;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_index      = '0;
  logic [TOL_W-1:0]    cfg_data       = '0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic [MZ_W-1:0]     peak_mz        = '0;
  logic [LEVEL_W-1:0]  peak_intensity = '0;
  logic                last_peak      = 1'b0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [CHAN_W-1:0]   channel;
  logic [LEVEL_W-1:0]  abundance;
  logic                last;

  // Shadow of the matcher state
  logic                model_set;
  logic [TOL_W-1:0]    model_tol;
  logic [MZ_W-1:0]     kept_mz [10];
  logic [LEVEL_W-1:0]  kept_level [10];
  logic                fresh_spectrum;

  abundance_t          abund_q[$];
  plan_row_t           plan[$];
  int                  errors      = 0;
  int                  cycle_count = 0;
  int                  stall_left  = 0;
  logic                idle_on     = 1'b0;

  reporter_peak_nearest_match uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .peak_mz        (peak_mz),
    .peak_intensity (peak_intensity),
    .last_peak      (last_peak),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .channel        (channel),
    .abundance      (abundance),
    .last           (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [MZ_W-1:0] mz_gap(input logic [MZ_W-1:0] a,
                                             input logic [MZ_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Fold one peak into the kept set; on the last peak queue the abundances if any channel is within tolerance
  function automatic int fold_peak(input logic [MZ_W-1:0] mz,
                                   input logic [LEVEL_W-1:0] level,
                                   input logic fin);
    int         n;
    logic       hit;
    abundance_t r;
    n = model_set ? SIZE_EIGHT : SIZE_TEN;
    hit = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (fresh_spectrum || mz_gap(mz, REPORTER_MZ[model_set][k]) <
          mz_gap(kept_mz[k], REPORTER_MZ[model_set][k]) ||
          (mz_gap(mz, REPORTER_MZ[model_set][k]) ==
           mz_gap(kept_mz[k], REPORTER_MZ[model_set][k]) && mz > kept_mz[k])) begin
        kept_mz[k] = mz;
        kept_level[k] = level;
      end
    end
    fresh_spectrum = 1'b0;
    if (!fin) return 0;
    fresh_spectrum = 1'b1;
    for (int k = 0; k < n; k++) begin
      if (mz_gap(kept_mz[k], REPORTER_MZ[model_set][k]) < model_tol) hit = 1'b1;
    end
    if (!hit) return 0;
    for (int k = 0; k < n; k++) begin
      r.chan = CHAN_W'(k);
      r.level = (mz_gap(kept_mz[k], REPORTER_MZ[model_set][k]) < model_tol) ?
                kept_level[k] : '0;
      r.fin = (k == n - 1);
      abund_q.push_back(r);
    end
    return n;
  endfunction

  function automatic plan_row_t peak_row(input logic [MZ_W-1:0] mz,
                                         input logic [LEVEL_W-1:0] level,
                                         input logic fin);
    plan_row_t r;
    r = '0;
    r.kind = ROW_PEAK;
    r.mz = mz;
    r.level = level;
    r.fin = fin;
    return r;
  endfunction

  // Peak whose results are typed in: hit_level on one channel, zero elsewhere
  function automatic plan_row_t typed_row(input logic [MZ_W-1:0] mz,
                                          input logic [LEVEL_W-1:0] level,
                                          input logic fin, input int n_res,
                                          input int hit_chan,
                                          input logic [LEVEL_W-1:0] hit_level);
    plan_row_t r;
    r = peak_row(mz, level, fin);
    r.typed = 1'b1;
    r.n_res = (CHAN_W + 1)'(n_res);
    r.hit_chan = CHAN_W'(hit_chan);
    r.hit_level = hit_level;
    return r;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_W-1:0] idx,
                                        input logic [TOL_W-1:0] data);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  // Offer one peak, with an optional idle burst first; fold it in when taken
  task automatic send_peak(input logic [MZ_W-1:0] mz, input logic [LEVEL_W-1:0] level,
                           input logic fin, output int n_out);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    peak_mz <= mz;
    peak_intensity <= level;
    last_peak <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_out = fold_peak(mz, level, fin);
  endtask

  // Wait for every queued abundance, then let a silent drain finish
  task automatic settle();
    while (abund_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_W-1:0] idx, input logic [TOL_W-1:0] data);
    in_valid <= 1'b0;
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_LABEL_SET: model_set = data[0];
      REG_TOLERANCE: model_tol = data;
      default: ;
    endcase
  endtask

  // Stall the result side in bursts of random length while idle_on is set
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest queued abundance
  always @(posedge clk) begin
    abundance_t want;
    if (!rst && out_valid && !out_stall) begin
      if (abund_q.size() == 0) begin
        $error("unexpected result: channel %0d abundance %0d last %0d",
               channel, abundance, last);
        errors++;
      end else begin
        want = abund_q.pop_front();
        if (channel !== want.chan) begin
          $error("channel: expected %0d, got %0d", want.chan, channel);
          errors++;
        end
        if (abundance !== want.level) begin
          $error("abundance: expected %0d, got %0d", want.level, abundance);
          errors++;
        end
        if (last !== want.fin) begin
          $error("last: expected %0d, got %0d", want.fin, last);
          errors++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    abundance_t       r;
    int               n;
    int               sent;
    int               len;
    int               pick;
    int               spectra_left;
    logic             calm;
    logic [TOL_W-1:0] tol;
    logic [MZ_W-1:0]  mz;
    logic [MZ_W-1:0]  prev_mz;
    logic [MZ_W-1:0]  target;
    logic [MZ_W-1:0]  span;

    model_set = LABEL_SET_RST;
    model_tol = TOLERANCE_RST;
    fresh_spectrum = 1'b1;
    for (int k = 0; k < 10; k++) begin
      kept_mz[k] = '0;
      kept_level[k] = '0;
    end

    // Directed plan: extremes, ties, tolerance edges, register corners
    plan.push_back(typed_row(32'd1240000, 32'hFFFFFFFF, 1'b1, 10, 0, 32'hFFFFFFFF));
    plan.push_back(typed_row(32'd0, 32'd1, 1'b1, 0, 0, 32'd0));
    plan.push_back(typed_row(32'hFFFFFFFF, 32'd2, 1'b1, 0, 0, 32'd0));
    plan.push_back(typed_row(32'd1330000, 32'd0, 1'b1, 10, 9, 32'd0));
    // equal distance on both sides, larger mass wins
    plan.push_back(peak_row(32'd1249900, 32'd11, 1'b0));
    plan.push_back(peak_row(32'd1250100, 32'd12, 1'b0));
    // just inside and exactly at the tolerance
    plan.push_back(peak_row(32'd1273999, 32'd13, 1'b0));
    plan.push_back(peak_row(32'd1276000, 32'd14, 1'b0));
    // equal masses, the earlier peak stays
    plan.push_back(peak_row(32'd1300000, 32'd15, 1'b0));
    plan.push_back(peak_row(32'd1300000, 32'd16, 1'b1));
    plan.push_back(reg_row(REG_TOLERANCE, 16'd0));
    plan.push_back(typed_row(32'd1240000, 32'd5, 1'b1, 0, 0, 32'd0));
    plan.push_back(reg_row(REG_LABEL_SET, 16'hFFFF));
    plan.push_back(reg_row(REG_TOLERANCE, 16'hFFFF));
    plan.push_back(peak_row(32'd1121000, 32'd7, 1'b0));
    plan.push_back(peak_row(32'd1256534, 32'd8, 1'b1));
    plan.push_back(reg_row(REG_LABEL_SET, 16'hFFFE));
    plan.push_back(reg_row(REG_SPARE_2, 16'h0000));
    plan.push_back(reg_row(REG_SPARE_3, 16'hFFFF));
    plan.push_back(reg_row(REG_TOLERANCE, 16'd1));
    // label set switched in the middle of a spectrum
    plan.push_back(peak_row(32'd1260000, 32'd9, 1'b0));
    plan.push_back(reg_row(REG_LABEL_SET, 16'd1));
    plan.push_back(peak_row(32'd1141112, 32'hAAAA5555, 1'b1));
    plan.push_back(reg_row(REG_TOLERANCE, 16'd4000));
    plan.push_back(typed_row(32'd1191000, 32'h5555AAAA, 1'b1, 8, 7, 32'h5555AAAA));

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    idle_on <= 1'b1;

    // Walk the directed plan
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        program_reg(plan[i].idx, plan[i].data);
      end else begin
        send_peak(plan[i].mz, plan[i].level, plan[i].fin, n);
        if (plan[i].typed) begin
          // replace the computed abundances with the typed ones
          repeat (n) void'(abund_q.pop_back());
          for (int k = 0; k < plan[i].n_res; k++) begin
            r.chan = CHAN_W'(k);
            r.level = (k == plan[i].hit_chan) ? plan[i].hit_level : '0;
            r.fin = (k == plan[i].n_res - 1);
            abund_q.push_back(r);
          end
        end
      end
    end

    // Random spectra: mostly peaks near reporter masses, some mirrors and noise
    sent = 0;
    spectra_left = 0;
    calm = 1'b0;
    target = REPORTER_MZ[0][0];
    prev_mz = target;
    while (sent < RANDOM_PEAKS) begin
      if (spectra_left == 0) begin
        program_reg(REG_LABEL_SET, 16'($urandom));
        case ($urandom_range(0, 5))
          0: tol = 16'd0;
          1: tol = 16'hFFFF;
          2, 3: tol = 16'd4000;
          default: tol = 16'($urandom_range(1, 20000));
        endcase
        program_reg(REG_TOLERANCE, tol);
        spectra_left = $urandom_range(3, 8);
        calm = ($urandom_range(0, 3) == 0);
      end
      idle_on <= !calm && (sent < RANDOM_PEAKS - CALM_TAIL);
      len = $urandom_range(1, 12);
      for (int p = 0; p < len; p++) begin
        pick = $urandom_range(0, 9);
        if (pick < 6 || (p == 0 && pick < 8)) begin
          target = REPORTER_MZ[model_set][$urandom_range(0, model_set ? 7 : 9)];
          span = {16'd0, model_tol};
          span = span + span / 2 + 8;
          mz = target + $urandom_range(0, 2 * span) - span;
          prev_mz = mz;
        end else if (pick < 8) begin
          // same mass again, or the mirror image across the reporter mass
          mz = $urandom_range(0, 1) ? prev_mz : 2 * target - prev_mz;
        end else begin
          mz = $urandom();
        end
        send_peak(mz, $urandom(), p == len - 1, n);
        sent++;
      end
      spectra_left--;
    end

    // Drain and report
    in_valid <= 1'b0;
    idle_on <= 1'b0;
    settle();
    if (errors == 0 && abund_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/rpnm_pkg.sv
hdl/rpnm_cell.sv
hdl/reporter_peak_nearest_match.sv
tb/testbench.sv
